// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file aes128_inv_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: rtl/core/aes128_inv_pkg.sv
package aes128_inv_pkg;
	localparam int Rounds = 10;
	localparam int KeyDepth = Rounds + 1;
	localparam int SlotW = 4;
	localparam int RndW = $clog2(Rounds + 1);

	localparam logic CmdLoad = 1'b0;
	localparam logic CmdDecrypt = 1'b1;

	typedef struct packed {
		logic [0:0] cmd;
		logic [SlotW-1:0] key_slot;
		logic [63:0] data_hi;
		logic [63:0] data_lo;
	} in_item_t;

	typedef struct packed {
		logic [63:0] plain_hi;
		logic [63:0] plain_lo;
	} out_item_t;

	// Key store request from the controller to the key memory.
	typedef struct packed {
		logic we;
		logic [RndW-1:0] addr;
		logic [127:0] wdata;
	} key_req_t;

	localparam logic [7:0] InvSbox [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of the state sits at bits 127-8i.
	function automatic logic [7:0] get_b(input logic [127:0] s, input int i);
		return s[127 - 8*i -: 8];
	endfunction

	function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8*(4*c + r) -: 8] = InvSbox[get_b(s, 4*((c - r + 4) % 4) + r)];
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] inv_mix(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a, a2, a4, a8;
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				a = get_b(s, 4*c + j);
				a2 = xt(a);
				a4 = xt(a2);
				a8 = xt(a4);
				m9[j] = a8 ^ a;
				mb[j] = a8 ^ a2 ^ a;
				md[j] = a8 ^ a4 ^ a;
				me[j] = a8 ^ a4 ^ a2;
			end
			t[127 - 8*(4*c) -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
			t[127 - 8*(4*c+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
			t[127 - 8*(4*c+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
			t[127 - 8*(4*c+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
		end
		return t;
	endfunction
endpackage

// File: rtl/core/aes128_inv_if.sv
interface aes128_inv_in_if;
	import aes128_inv_pkg::*;
	logic valid;
	logic ready;
	in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface aes128_inv_out_if;
	import aes128_inv_pkg::*;
	logic valid;
	logic ready;
	out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/aes128_inv_keymem.sv
module aes128_inv_keymem (
	input logic clk,
	input aes128_inv_pkg::key_req_t req,
	output logic [127:0] rdata
);
	import aes128_inv_pkg::*;

	logic [127:0] mem [KeyDepth];

	// One read, one write per cycle if we; rdata registered.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata <= mem[req.addr];
	end
endmodule

// File: rtl/core/aes128_inv_ctrl.sv
module aes128_inv_ctrl (
	input logic clk,
	input logic arst_n,
	aes128_inv_in_if.sink in_ch,
	aes128_inv_out_if.source out_ch,
	output aes128_inv_pkg::key_req_t key_req,
	input logic [127:0] key_rdata
);
	import aes128_inv_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;
	logic [RndW-1:0] rnd_q;
	logic first_q;
	logic [127:0] blk_q;
	logic out_valid_q;
	out_item_t out_q;
	logic in_xfer;
	logic out_load;
	logic [127:0] keyed;

	// A new item is taken only while the sequencer is idle.
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_xfer = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_q;
	assign keyed = blk_q ^ key_rdata;
	// The finished block moves to the output register once that register is free.
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);

	// Key memory address: load slot on a load, otherwise the round being read.
	always_comb begin
		key_req.we = in_xfer && (in_ch.payload.cmd == CmdLoad)
			&& (in_ch.payload.key_slot <= SlotW'(Rounds));
		key_req.wdata = {in_ch.payload.data_hi, in_ch.payload.data_lo};
		if (in_xfer && (in_ch.payload.cmd == CmdLoad)) begin
			key_req.addr = in_ch.payload.key_slot[RndW-1:0];
		end else if (in_xfer) begin
			key_req.addr = RndW'(Rounds);
		end else if (rnd_q != '0) begin
			key_req.addr = rnd_q - RndW'(1);
		end else begin
			key_req.addr = '0;
		end
	end

	// Round sequencer: one key read and one round per cycle in ST_RUN.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			rnd_q <= '0;
			first_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && (in_ch.payload.cmd == CmdDecrypt)) begin
						state_q <= ST_RUN;
						rnd_q <= RndW'(Rounds);
						first_q <= 1'b1;
					end
				end
				ST_RUN: begin
					first_q <= 1'b0;
					if (rnd_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						rnd_q <= rnd_q - RndW'(1);
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: key rdata for round rnd_q is valid in ST_RUN.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			blk_q <= {in_ch.payload.data_hi, in_ch.payload.data_lo};
		end else if (state_q == ST_RUN) begin
			if (rnd_q == '0) begin
				blk_q <= keyed;
			end else if (first_q) begin
				blk_q <= inv_shift_sub(keyed);
			end else begin
				blk_q <= inv_shift_sub(inv_mix(keyed));
			end
		end
		if (out_load) begin
			out_q <= {blk_q[127:64], blk_q[63:0]};
		end
	end
endmodule

// File: rtl/core/aes128_inverse_cipher_core.sv
// AES-128 inverse cipher with a user-loaded key schedule.
// Input channel in_ch carries cmd, key_slot, data_hi and data_lo. A load
// (cmd 0) writes round key key_slot (0 to 10) into the key memory and
// gives no result; a slot above 10 is dropped.
// A decrypt (cmd 1) gives one plaintext block on out_ch.
// A decrypt loads its block, runs one round per cycle in ST_RUN, set by the
// single read port of the key memory that supplies one round key per cycle
// over eleven key additions, then waits in ST_DONE for the output register.
// Items are taken only while no decrypt is in progress, loads one per cycle.
// The output register holds a finished result while the receiver stalls;
// the next decrypt may run meanwhile and waits only to hand its result over.
// Reset clears the control state; the key memory is not cleared, and every
// slot must be loaded before a decrypt uses it.
module aes128_inverse_cipher_core (
	input logic clk,
	input logic arst_n,
	aes128_inv_in_if.sink in_ch,
	aes128_inv_out_if.source out_ch
);
	import aes128_inv_pkg::*;

	key_req_t key_req;
	logic [127:0] key_rdata;

	aes128_inv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.key_req(key_req), .key_rdata(key_rdata)
	);

	aes128_inv_keymem u_keymem (.clk(clk), .req(key_req), .rdata(key_rdata));
endmodule

// File: rtl/core/aes128_inv_chk.sv
`include "assert_macros.svh"
module aes128_inv_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_cmd,
	input logic out_valid,
	input logic out_ready,
	input logic [127:0] out_data
);
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
	`CHK_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_data), "result changed")
	`CHK_NEXT(a_busy, clk, arst_n, in_valid && in_ready && in_cmd, !in_ready, "accepted during decrypt")
	`CHK_NEXT(a_no_early, clk, arst_n, in_valid && in_ready && in_cmd && !out_valid, !out_valid, "early result")
endmodule

bind aes128_inverse_cipher_core aes128_inv_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.in_cmd(in_ch.payload.cmd), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_data(out_ch.payload)
);
